// ===== rtl/core/sbgp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbgp_pkg
// Shared types and codes of the serpentine bar graph painter: command and
// result payloads, controller states, decode outcomes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbgp_pkg;

  // number of bar slots in the bar table
  localparam int unsigned NumBars = 8;

  // command codes
  localparam logic [1:0] OP_SET       = 2'd0;
  localparam logic [1:0] OP_INCREASE  = 2'd1;
  localparam logic [1:0] OP_CONFIGURE = 2'd2;

  // bar direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // one accepted command beat
  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] bar;
    logic [7:0] amount;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic [7:0] blue_in;
    logic [7:0] bar_size;
    logic       wrap_enable;
    logic [1:0] direction;
  } sbgp_item_t;

  // one result beat
  typedef struct packed {
    logic       write_enable;
    logic [5:0] led_index;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] blue_out;
    logic       error;
    logic       last;
  } sbgp_pix_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_PAINT,
    ST_SINGLE
  } sbgp_state_e;

  // outcome of decoding a command against the bar table
  typedef enum logic [1:0] {
    KIND_REFUSE,
    KIND_EMPTY,
    KIND_PAINT,
    KIND_MOD
  } sbgp_kind_e;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic decide;
    logic apply_mod;
    logic emit_pixel;
    logic emit_single;
  } sbgp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    sbgp_kind_e kind;
    logic       mod_done;
    logic       paint_last;
    logic       out_free;
  } sbgp_sts_t;

endpackage

// ===== rtl/core/sbgp_if.sv =====
// ----------------------------------------------------------------------------
// sbgp_if
// Valid/ready channels of the bar graph painter: the command channel and
// the pixel result channel.
// ----------------------------------------------------------------------------
interface sbgp_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [2:0] bar;
  logic [7:0] amount;
  logic [7:0] green_in;
  logic [7:0] red_in;
  logic [7:0] blue_in;
  logic [7:0] bar_size;
  logic       wrap_enable;
  logic [1:0] direction;

  modport source (
    output valid, operation, bar, amount, green_in, red_in, blue_in,
           bar_size, wrap_enable, direction,
    input  ready
  );

  modport sink (
    input  valid, operation, bar, amount, green_in, red_in, blue_in,
           bar_size, wrap_enable, direction,
    output ready
  );
endinterface

interface sbgp_pix_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [5:0] led_index;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic [7:0] blue_out;
  logic       error;
  logic       last;

  modport source (
    output valid, write_enable, led_index, green_out, red_out, blue_out,
           error, last,
    input  ready
  );

  modport sink (
    input  valid, write_enable, led_index, green_out, red_out, blue_out,
           error, last,
    output ready
  );
endinterface

// ===== rtl/core/sbgp_mod.sv =====
// ----------------------------------------------------------------------------
// sbgp_mod
// Restoring remainder unit: 9-bit dividend by nonzero 8-bit divisor, one
// quotient bit per cycle, done pulses after nine steps.
// ----------------------------------------------------------------------------
module sbgp_mod (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [8:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic       done_o,
  output logic [7:0] rem_o
);

  logic       busy_q;
  logic       done_q;
  logic [3:0] cnt_q;
  logic [8:0] dvd_q;
  logic [8:0] rem_q;
  logic [7:0] div_q;
  logic [8:0] trial;
  logic [8:0] rem_d;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q[7:0], dvd_q[8]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = trial - {1'b0, div_q};
    end else begin
      rem_d = trial;
    end
  end

  // control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 4'd8;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[7:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[7:0];

endmodule

// ===== rtl/core/sbgp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbgp_ctrl
// Command sequencer: accepts a command, has the datapath decode it, waits
// for the modulo step of a wrapped increase and paces the result beats.
// ----------------------------------------------------------------------------
module sbgp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sbgp_pkg::sbgp_sts_t sts_i,
  output sbgp_pkg::sbgp_ctl_t ctl_o
);

  sbgp_pkg::sbgp_state_e state_q;
  sbgp_pkg::sbgp_state_e state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbgp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sbgp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = sbgp_pkg::ST_DECODE;
        end
      end
      sbgp_pkg::ST_DECODE: begin
        ctl_o.decide = 1'b1;
        case (sts_i.kind)
          sbgp_pkg::KIND_PAINT: state_d = sbgp_pkg::ST_PAINT;
          sbgp_pkg::KIND_MOD:   state_d = sbgp_pkg::ST_MOD;
          default:              state_d = sbgp_pkg::ST_SINGLE;
        endcase
      end
      sbgp_pkg::ST_MOD: begin
        if (sts_i.mod_done) begin
          ctl_o.apply_mod = 1'b1;
          state_d         = sbgp_pkg::ST_PAINT;
        end
      end
      sbgp_pkg::ST_PAINT: begin
        if (sts_i.out_free) begin
          ctl_o.emit_pixel = 1'b1;
          if (sts_i.paint_last) begin
            state_d = sbgp_pkg::ST_IDLE;
          end
        end
      end
      sbgp_pkg::ST_SINGLE: begin
        if (sts_i.out_free) begin
          ctl_o.emit_single = 1'b1;
          state_d           = sbgp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbgp_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a beat is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.emit_pixel || ctl_o.emit_single) |-> sts_i.out_free)
    else $error("result loaded while output register busy");

  // an accepted command is decoded in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.latch |=> state_q == sbgp_pkg::ST_DECODE)
    else $error("accepted command not decoded");

  // the modulo unit only finishes while it is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mod_done |-> state_q == sbgp_pkg::ST_MOD)
    else $error("modulo result arrived outside the wait state");

  // the last pixel of a command frees the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.emit_pixel && sts_i.paint_last) |=> state_q == sbgp_pkg::ST_IDLE)
    else $error("sequencer busy after last pixel");
`endif

endmodule

// ===== rtl/core/sbgp_datapath.sv =====
// ----------------------------------------------------------------------------
// sbgp_datapath
// Bar table, orientation register, command decode, paint level counter,
// serpentine position and the output register.
// ----------------------------------------------------------------------------
module sbgp_datapath #(
  parameter int unsigned MATRIX_WIDTH  = 8,
  parameter int unsigned MATRIX_HEIGHT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  input  sbgp_pkg::sbgp_item_t item_i,
  input  sbgp_pkg::sbgp_ctl_t  ctl_i,
  output sbgp_pkg::sbgp_sts_t  sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sbgp_pkg::sbgp_pix_t  pix_o
);

  localparam int unsigned LvlMax = (MATRIX_WIDTH > MATRIX_HEIGHT) ?
                                   MATRIX_WIDTH : MATRIX_HEIGHT;
  localparam int unsigned LvlW   = (LvlMax > 2) ? $clog2(LvlMax) : 1;
  localparam int unsigned CntW   = $clog2(LvlMax + 1);
  localparam int unsigned BarW   = $clog2(sbgp_pkg::NumBars);

  // orientation and bar table
  logic        vertical_q;
  logic [7:0]  level_q  [sbgp_pkg::NumBars];
  logic [7:0]  limit_q  [sbgp_pkg::NumBars];
  logic        wraps_q  [sbgp_pkg::NumBars];
  logic [23:0] color_q  [sbgp_pkg::NumBars];

  // latched command and paint progress
  sbgp_pkg::sbgp_item_t item_q;
  logic [LvlW-1:0]      lvl_q;
  logic [CntW-1:0]      to_q;
  logic [7:0]           lit_q;
  logic                 refuse_q;
  logic                 out_valid_q;
  sbgp_pkg::sbgp_pix_t  pix_q;

  // decode signals
  logic [CntW-1:0]     nb;
  logic [CntW-1:0]     nl;
  logic [BarW-1:0]     bar_idx;
  logic [7:0]          cur;
  logic [7:0]          lim;
  logic                wr;
  logic [8:0]          sum;
  logic                bar_bad;
  logic                dir_bad;
  sbgp_pkg::sbgp_kind_e kind;
  logic                upd_level;
  logic                upd_color;
  logic                upd_cfg;
  logic [7:0]          new_level;
  logic [7:0]          from_lvl;
  logic [8:0]          to_lvl;
  logic [8:0]          to_clip;
  logic [7:0]          lit;
  logic                mod_done;
  logic [7:0]          mod_rem;
  logic                level_we;
  logic [7:0]          level_wd;
  logic                color_we;
  logic                out_free;
  logic                paint_last;
  logic [15:0]         col;
  logic [15:0]         pos;
  logic                lit_now;

  assign nb      = vertical_q ? CntW'(MATRIX_WIDTH) : CntW'(MATRIX_HEIGHT);
  assign nl      = vertical_q ? CntW'(MATRIX_HEIGHT) : CntW'(MATRIX_WIDTH);
  assign bar_idx = item_q.bar;
  assign cur     = level_q[bar_idx];
  assign lim     = limit_q[bar_idx];
  assign wr      = wraps_q[bar_idx];
  assign sum     = {1'b0, cur} + {1'b0, item_q.amount};
  assign bar_bad = 8'(item_q.bar) >= 8'(nb);
  assign dir_bad = vertical_q ?
                   (item_q.direction == sbgp_pkg::DIR_LEFT ||
                    item_q.direction == sbgp_pkg::DIR_RIGHT) :
                   (item_q.direction == sbgp_pkg::DIR_UP ||
                    item_q.direction == sbgp_pkg::DIR_DOWN);

  // command decode against the addressed bar
  always_comb begin
    kind      = sbgp_pkg::KIND_REFUSE;
    upd_level = 1'b0;
    upd_color = 1'b0;
    upd_cfg   = 1'b0;
    new_level = item_q.amount;
    from_lvl  = '0;
    to_lvl    = 9'(nl);
    lit       = item_q.amount;
    case (item_q.operation)
      sbgp_pkg::OP_SET: begin
        if (!bar_bad && item_q.amount <= lim) begin
          kind      = sbgp_pkg::KIND_PAINT;
          upd_level = 1'b1;
          upd_color = 1'b1;
        end
      end
      sbgp_pkg::OP_INCREASE: begin
        if (!bar_bad) begin
          if (sum > {1'b0, lim}) begin
            if (wr) begin
              if (lim != 8'd0) begin
                kind = sbgp_pkg::KIND_MOD;
              end
            end else if (cur == lim) begin
              kind = sbgp_pkg::KIND_EMPTY;
            end else begin
              kind      = sbgp_pkg::KIND_PAINT;
              upd_level = 1'b1;
              upd_color = 1'b1;
              new_level = lim;
              from_lvl  = cur;
              to_lvl    = {1'b0, lim};
              lit       = lim;
            end
          end else begin
            kind      = sbgp_pkg::KIND_PAINT;
            upd_level = 1'b1;
            upd_color = 1'b1;
            new_level = sum[7:0];
            from_lvl  = cur;
            to_lvl    = sum;
            lit       = sum[7:0];
          end
        end
      end
      sbgp_pkg::OP_CONFIGURE: begin
        if (!dir_bad && item_q.bar_size <= 8'(nl) &&
            item_q.amount <= item_q.bar_size && !bar_bad) begin
          kind      = sbgp_pkg::KIND_PAINT;
          upd_level = 1'b1;
          upd_cfg   = 1'b1;
          to_lvl    = {1'b0, item_q.amount};
        end
      end
      default: begin
        kind = sbgp_pkg::KIND_REFUSE;
      end
    endcase
    to_clip = (to_lvl > 9'(nl)) ? 9'(nl) : to_lvl;
    if (kind == sbgp_pkg::KIND_PAINT && {1'b0, from_lvl} >= to_clip) begin
      kind = sbgp_pkg::KIND_EMPTY;
    end
  end

  // wrapped increase remainder
  sbgp_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.decide && kind == sbgp_pkg::KIND_MOD),
    .dividend_i (sum),
    .divisor_i  (lim),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign level_we = (ctl_i.decide && upd_level) || ctl_i.apply_mod;
  assign level_wd = ctl_i.apply_mod ? mod_rem : new_level;
  assign color_we = (ctl_i.decide && upd_color) || ctl_i.apply_mod;

  // orientation register and bar table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertical_q <= 1'b1;
      for (int i = 0; i < sbgp_pkg::NumBars; i++) begin
        level_q[i] <= '0;
        limit_q[i] <= 8'(MATRIX_HEIGHT);
        wraps_q[i] <= 1'b1;
        color_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        vertical_q <= cfg_data_i;
      end
      if (level_we) begin
        level_q[bar_idx] <= level_wd;
      end
      if (color_we) begin
        color_q[bar_idx] <= {item_q.green_in, item_q.red_in, item_q.blue_in};
      end
      if (ctl_i.decide && upd_cfg) begin
        limit_q[bar_idx] <= item_q.bar_size;
        wraps_q[bar_idx] <= item_q.wrap_enable;
      end
    end
  end

  // command latch and paint range
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      item_q <= item_i;
    end
    if (ctl_i.decide) begin
      refuse_q <= (kind == sbgp_pkg::KIND_REFUSE);
      lvl_q    <= from_lvl[LvlW-1:0];
      to_q     <= to_clip[CntW-1:0];
      lit_q    <= lit;
    end else if (ctl_i.apply_mod) begin
      lvl_q <= '0;
      to_q  <= nl;
      lit_q <= mod_rem;
    end else if (ctl_i.emit_pixel) begin
      lvl_q <= lvl_q + LvlW'(1);
    end
  end

  // serpentine position of the current level
  assign col = lvl_q[0] ? (16'(nb) - 16'd1 - 16'(item_q.bar)) : 16'(item_q.bar);
  assign pos = col + 16'(nb) * 16'(lvl_q);
  assign lit_now    = 8'(lvl_q) < lit_q;
  assign paint_last = (8'(lvl_q) + 8'd1) == 8'(to_q);
  assign out_free   = !out_valid_q || out_ready_i;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit_pixel || ctl_i.emit_single) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output beat
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_pixel) begin
      pix_q.write_enable <= 1'b1;
      pix_q.led_index    <= pos[5:0];
      pix_q.green_out    <= lit_now ? color_q[bar_idx][23:16] : 8'd0;
      pix_q.red_out      <= lit_now ? color_q[bar_idx][15:8] : 8'd0;
      pix_q.blue_out     <= lit_now ? color_q[bar_idx][7:0] : 8'd0;
      pix_q.error        <= 1'b0;
      pix_q.last         <= paint_last;
    end else if (ctl_i.emit_single) begin
      pix_q.write_enable <= 1'b0;
      pix_q.led_index    <= '0;
      pix_q.green_out    <= '0;
      pix_q.red_out      <= '0;
      pix_q.blue_out     <= '0;
      pix_q.error        <= refuse_q;
      pix_q.last         <= 1'b1;
    end
  end

  assign sts_o.kind       = kind;
  assign sts_o.mod_done   = mod_done;
  assign sts_o.paint_last = paint_last;
  assign sts_o.out_free   = out_free;
  assign out_valid_o      = out_valid_q;
  assign pix_o            = pix_q;

endmodule

// ===== rtl/core/serpentine_bar_graph_painter_top.sv =====
// ----------------------------------------------------------------------------
// serpentine_bar_graph_painter_top
// Turns bar graph commands (set, increase, configure) into LED pixel writes
// for a serpentine strip. A command is taken when the block is free, it is
// decoded against the eight-entry bar table, and then one result beat
// leaves per cycle while the sink takes them: a refused or empty command
// gives one beat, a set or a wrapped increase one per level, an increase
// one per newly lit level and a configure one per level up to its amount.
// An increase that wraps first waits for the bit-serial remainder unit.
// The sequencer works on one command at a time: it takes no new command
// until the last beat of the current one is loaded, passing through the
// accept, decode, modulo wait and paint steps. The orientation register
// may be written only while idle.
// ----------------------------------------------------------------------------
module serpentine_bar_graph_painter_top #(
  parameter int unsigned MATRIX_WIDTH  = 8,
  parameter int unsigned MATRIX_HEIGHT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  sbgp_cmd_if.sink          cmd_i,
  sbgp_pix_if.source        pix_o
);

  sbgp_pkg::sbgp_item_t item;
  sbgp_pkg::sbgp_ctl_t  ctl;
  sbgp_pkg::sbgp_sts_t  sts;
  sbgp_pkg::sbgp_pix_t  pix;
  logic                 in_ready;
  logic                 out_valid;

  // gather the command beat
  assign item.operation   = cmd_i.operation;
  assign item.bar         = cmd_i.bar;
  assign item.amount      = cmd_i.amount;
  assign item.green_in    = cmd_i.green_in;
  assign item.red_in      = cmd_i.red_in;
  assign item.blue_in     = cmd_i.blue_in;
  assign item.bar_size    = cmd_i.bar_size;
  assign item.wrap_enable = cmd_i.wrap_enable;
  assign item.direction   = cmd_i.direction;
  assign cmd_i.ready      = in_ready;

  // sequencer
  sbgp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // bar table and pixel path
  sbgp_datapath #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (pix_o.ready),
    .pix_o       (pix)
  );

  // drive the result channel
  assign pix_o.valid        = out_valid;
  assign pix_o.write_enable = pix.write_enable;
  assign pix_o.led_index    = pix.led_index;
  assign pix_o.green_out    = pix.green_out;
  assign pix_o.red_out      = pix.red_out;
  assign pix_o.blue_out     = pix.blue_out;
  assign pix_o.error        = pix.error;
  assign pix_o.last         = pix.last;

endmodule
